// ----- src/divider_64bit_signed_unsigned_defines.svh -----
// Assertion macros for the divider pipeline.
// Included by the modules that check their own stage registers.
`ifndef DIVIDER_64BIT_SIGNED_UNSIGNED_DEFINES_SVH
`define DIVIDER_64BIT_SIGNED_UNSIGNED_DEFINES_SVH
`ifndef SYNTHESIS
`define DIV64_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("divider assertion failed");
`define DIV64_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("divider assertion failed");
`else
`define DIV64_ASSERT(name, clk, rst_n, prop)
`define DIV64_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

// ----- src/div64_pkg.sv -----
// Types and constants shared by the divider pipeline.
// No dependencies.
`timescale 1ns / 1ps
package div64_pkg;
	localparam int ITEM_WIDTH = 64;

	typedef struct packed {
		logic                  kind;
		logic [ITEM_WIDTH-1:0] dividend;
		logic [ITEM_WIDTH-1:0] divisor;
	} in_item_t;

	typedef struct packed {
		logic [ITEM_WIDTH-1:0] quotient;
		logic [ITEM_WIDTH-1:0] remainder;
		logic                  divide_by_zero;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic q_neg;
		logic r_neg;
		logic dz;
	} ctrl_t;
endpackage

// ----- src/div64_prep.sv -----
// First stage: takes the operand magnitudes and the sign and zero flags.
// Depends on div64_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "divider_64bit_signed_unsigned_defines.svh"
module div64_prep #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  div64_pkg::in_item_t     in_item,
	output div64_pkg::ctrl_t        ctrl_s1,
	output logic [DATA_WIDTH-1:0]   rem_s1,
	output logic [DATA_WIDTH-1:0]   nq_s1,
	output logic [DATA_WIDTH-1:0]   d_s1
);
	import div64_pkg::*;

	logic [DATA_WIDTH-1:0] n;
	logic [DATA_WIDTH-1:0] d;
	logic                  dz;
	logic                  n_neg;
	logic                  d_neg;

	always_comb begin
		n     = in_item.dividend[DATA_WIDTH-1:0];
		d     = in_item.divisor[DATA_WIDTH-1:0];
		dz    = (d == '0);
		n_neg = in_item.kind & n[DATA_WIDTH-1] & ~dz;
		d_neg = in_item.kind & d[DATA_WIDTH-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1.valid <= in_valid;
			ctrl_s1.q_neg <= n_neg ^ d_neg;
			ctrl_s1.r_neg <= n_neg;
			ctrl_s1.dz    <= dz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= '0;
			nq_s1  <= n_neg ? (~n + DATA_WIDTH'(1)) : n;
			d_s1   <= d_neg ? (~d + DATA_WIDTH'(1)) : d;
		end
	end

	`DIV64_ASSERT(a_dz_no_sign, clk, arst_n, (ctrl_s1.valid && ctrl_s1.dz) |-> (!ctrl_s1.q_neg && !ctrl_s1.r_neg))
endmodule

// ----- src/div64_step.sv -----
// One restoring shift-subtract stage: decides one quotient bit.
// Depends on div64_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "divider_64bit_signed_unsigned_defines.svh"
module div64_step #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  div64_pkg::ctrl_t        ctrl_in,
	input  logic [DATA_WIDTH-1:0]   rem_in,
	input  logic [DATA_WIDTH-1:0]   nq_in,
	input  logic [DATA_WIDTH-1:0]   d_in,
	output div64_pkg::ctrl_t        ctrl_sn,
	output logic [DATA_WIDTH-1:0]   rem_sn,
	output logic [DATA_WIDTH-1:0]   nq_sn,
	output logic [DATA_WIDTH-1:0]   d_sn
);
	import div64_pkg::*;

	logic [DATA_WIDTH+1:0] diff;
	logic                  borrow;

	always_comb begin
		diff   = {1'b0, rem_in, nq_in[DATA_WIDTH-1]} - {2'b00, d_in};
		borrow = diff[DATA_WIDTH+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_sn <= '0;
		end else if (en) begin
			ctrl_sn <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sn <= borrow ? {rem_in[DATA_WIDTH-2:0], nq_in[DATA_WIDTH-1]}
			                 : diff[DATA_WIDTH-1:0];
			nq_sn  <= {nq_in[DATA_WIDTH-2:0], ~borrow};
			d_sn   <= d_in;
		end
	end

	`DIV64_ASSERT(a_rem_below_divisor, clk, arst_n, (ctrl_sn.valid && !ctrl_sn.dz) |-> (rem_sn < d_sn))
endmodule

// ----- src/div64_post.sv -----
// Last stage: applies the result signs and holds the output item.
// Depends on div64_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "divider_64bit_signed_unsigned_defines.svh"
module div64_post #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  div64_pkg::ctrl_t        ctrl_in,
	input  logic [DATA_WIDTH-1:0]   rem_in,
	input  logic [DATA_WIDTH-1:0]   nq_in,
	output logic                    out_valid,
	output div64_pkg::out_item_t    out_item
);
	import div64_pkg::*;

	logic      out_valid_q;
	out_item_t out_item_q;
	logic [DATA_WIDTH-1:0] q;
	logic [DATA_WIDTH-1:0] r;

	always_comb begin
		q = ctrl_in.q_neg ? (~nq_in + DATA_WIDTH'(1)) : nq_in;
		r = ctrl_in.r_neg ? (~rem_in + DATA_WIDTH'(1)) : rem_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctrl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item_q.quotient       <= ITEM_WIDTH'(q);
			out_item_q.remainder      <= ITEM_WIDTH'(r);
			out_item_q.divide_by_zero <= ctrl_in.dz;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`DIV64_ASSERT(a_dz_all_ones, clk, arst_n, (out_valid_q && out_item_q.divide_by_zero) |-> (out_item_q.quotient[DATA_WIDTH-1:0] == {DATA_WIDTH{1'b1}}))
	`DIV64_ASSERT(a_upper_zero, clk, arst_n, out_valid_q |-> (((out_item_q.quotient >> DATA_WIDTH) == '0) && ((out_item_q.remainder >> DATA_WIDTH) == '0)))
	`DIV64_ASSERT_NEXT(a_stall_holds, clk, arst_n, !en, $stable(out_item_q) && $stable(out_valid_q))
endmodule

// ----- src/divider_64bit_signed_unsigned.sv -----
// Top level of the pipelined signed/unsigned integer divider.
// Depends on div64_pkg, div64_prep, div64_step and div64_post.
`timescale 1ns / 1ps
// Divides dividend by divisor as unsigned or as two's complement numbers (kind)
// and returns quotient and remainder in one item; the quotient truncates toward
// zero and the remainder takes the dividend's sign. Only the low DATA_WIDTH bits
// of the operands are used and the upper result bits are zero. A zero divisor
// gives an all-ones quotient, the dividend as remainder and divide_by_zero set.
// The pipeline has one stage per quotient bit plus an input and an output stage,
// and a new item can be accepted every cycle while the output register is empty
// or its item is taken. When the output item is not taken, the whole pipeline
// holds.
module divider_64bit_signed_unsigned #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  div64_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output div64_pkg::out_item_t out_item
);
	import div64_pkg::*;

	logic                  en;
	ctrl_t                 ctrl_w [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_w  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] nq_w   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] d_w    [0:DATA_WIDTH];

	assign en       = ~out_valid | out_ready;
	assign in_ready = en;

	div64_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_item  (in_item),
		.ctrl_s1  (ctrl_w[0]),
		.rem_s1   (rem_w[0]),
		.nq_s1    (nq_w[0]),
		.d_s1     (d_w[0])
	);

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
		div64_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctrl_in (ctrl_w[i]),
			.rem_in  (rem_w[i]),
			.nq_in   (nq_w[i]),
			.d_in    (d_w[i]),
			.ctrl_sn (ctrl_w[i+1]),
			.rem_sn  (rem_w[i+1]),
			.nq_sn   (nq_w[i+1]),
			.d_sn    (d_w[i+1])
		);
	end

	div64_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctrl_in   (ctrl_w[DATA_WIDTH]),
		.rem_in    (rem_w[DATA_WIDTH]),
		.nq_in     (nq_w[DATA_WIDTH]),
		.out_valid (out_valid),
		.out_item  (out_item)
	);
endmodule
